>>> rtl/core/lphm_pkg.sv
package lphm_pkg;

  localparam int SLOT_BITS = 8;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS = 64;
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int FULL_LIMIT = (TABLE_SLOTS * 3) / 4;

  localparam logic [63:0] MIX_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_B = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_TAKE   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]            command;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic [COUNT_BITS-1:0] entry_count;
  } rsp_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_HASH   = 4'd2,
    OP_READ   = 4'd3,
    OP_NEXT   = 4'd4,
    OP_WRITE  = 4'd5,
    OP_UPDATE = 4'd6,
    OP_CLEAR  = 4'd7,
    OP_MOVE   = 4'd8,
    OP_SHASH  = 4'd9
  } op_t;

  typedef struct packed {
    op_t op;
    logic respond;
    logic [2:0] status;
    logic give_value;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic [1:0] command;
    logic occupied;
    logic key_match;
    logic stays;
    logic full;
  } stat_t;

endpackage

>>> rtl/core/lphm_hash.sv
module lphm_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] key,
  output logic        done,
  output logic [lphm_pkg::SLOT_BITS-1:0] home
);

  logic [63:0] x;
  logic [2:0]  step;
  logic [63:0] prod;
  logic [63:0] cst;

  // Each 64x64 multiply is built from three 32x32 products, one per cycle.
  always_comb begin
    cst = (step < 3'd4) ? lphm_pkg::MIX_A : lphm_pkg::MIX_B;
    prod = 64'd0;
    case (step[1:0])
      2'd0: prod = 64'(x[31:0]) * 64'(cst[31:0]);
      2'd1: prod = {x[31:0] * cst[63:32], 32'd0};
      2'd2: prod = {x[63:32] * cst[31:0], 32'd0};
      default: prod = 64'd0;
    endcase
  end

  logic [63:0] acc;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        step <= 3'd0;
        x <= key ^ (key >> lphm_pkg::MIX_SHIFT);
        acc <= 64'd0;
      end else if (busy) begin
        if (step[1:0] == 2'd3) begin
          x <= acc ^ (acc >> lphm_pkg::MIX_SHIFT);
          acc <= 64'd0;
          if (step == 3'd7) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          acc <= acc + prod;
        end
        step <= step + 3'd1;
      end
    end
  end

  assign home = x[lphm_pkg::SLOT_BITS-1:0];

endmodule

>>> rtl/core/lphm_datapath.sv
module lphm_datapath (
  input  logic             clk,
  input  logic             rst,
  input  lphm_pkg::req_t   req,
  input  lphm_pkg::cmd_t   cmd,
  output lphm_pkg::stat_t  stat,
  output lphm_pkg::rsp_t   rsp,
  output logic             rsp_valid
);

  localparam int SB = lphm_pkg::SLOT_BITS;
  localparam int N = lphm_pkg::TABLE_SLOTS;

  lphm_pkg::req_t r;
  logic [SB-1:0] pos;
  logic [SB-1:0] gap;
  logic [lphm_pkg::COUNT_BITS-1:0] count;
  logic [N-1:0] occ;
  logic [lphm_pkg::VALUE_BITS-1:0] held;

  logic [63:0] key_mem [N];
  logic [lphm_pkg::VALUE_BITS-1:0] val_mem [N];
  logic [63:0] rd_key;
  logic [lphm_pkg::VALUE_BITS-1:0] rd_val;
  logic rd_occ;

  logic hgo;
  logic hdone;
  logic [SB-1:0] home;
  logic [63:0] hkey;

  assign hgo = (cmd.op == lphm_pkg::OP_HASH) || (cmd.op == lphm_pkg::OP_SHASH);
  assign hkey = (cmd.op == lphm_pkg::OP_SHASH) ? rd_key : r.lookup_key;

  lphm_hash u_hash (
    .clk(clk), .rst(rst), .go(hgo), .key(hkey), .done(hdone), .home(home)
  );

  logic [SB-1:0] wr_addr;
  logic          wr_en;
  logic [63:0]   wr_key;
  logic [lphm_pkg::VALUE_BITS-1:0] wr_val;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_key = r.lookup_key;
    wr_val = r.entry_value;
    case (cmd.op)
      lphm_pkg::OP_WRITE: wr_en = 1'b1;
      lphm_pkg::OP_MOVE: begin
        wr_en = 1'b1;
        wr_addr = gap;
        wr_key = rd_key;
        wr_val = rd_val;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_en || cmd.op == lphm_pkg::OP_UPDATE) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[pos];
    rd_val <= val_mem[pos];
  end

  logic stays;
  always_comb begin
    if (gap < pos) begin
      stays = (gap < home) && (home <= pos);
    end else begin
      stays = (gap < home) || (home <= pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      count <= '0;
      rsp_valid <= 1'b0;
      rd_occ <= 1'b0;
    end else begin
      rsp_valid <= cmd.respond;
      rd_occ <= occ[pos];
      case (cmd.op)
        lphm_pkg::OP_LOAD: r <= req;
        lphm_pkg::OP_READ: pos <= home;
        lphm_pkg::OP_NEXT: pos <= pos + SB'(1);
        lphm_pkg::OP_WRITE: begin
          occ[pos] <= 1'b1;
          count <= count + 1'b1;
        end
        lphm_pkg::OP_CLEAR: begin
          occ[pos] <= 1'b0;
          count <= count - 1'b1;
          gap <= pos;
          held <= rd_val;
        end
        lphm_pkg::OP_MOVE: begin
          occ[gap] <= 1'b1;
          occ[pos] <= 1'b0;
          gap <= pos;
        end
        default: ;
      endcase
      if (cmd.respond) begin
        rsp.status <= cmd.status;
        rsp.found_value <= cmd.give_value
            ? ((r.command == lphm_pkg::CMD_TAKE) ? held : rd_val) : '0;
        rsp.entry_count <= (cmd.op == lphm_pkg::OP_WRITE) ? count + 1'b1 :
            (cmd.op == lphm_pkg::OP_CLEAR) ? count - 1'b1 : count;
      end
    end
  end

  assign stat.hash_done = hdone;
  assign stat.command = r.command;
  assign stat.occupied = rd_occ;
  assign stat.key_match = (rd_key == r.lookup_key);
  assign stat.stays = stays;
  assign stat.full = (32'(count) + 32'd1) >= 32'(lphm_pkg::FULL_LIMIT);

endmodule

>>> rtl/core/lphm_ctrl.sv
module lphm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lphm_pkg::stat_t stat,
  output lphm_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_HASH  = 8'b00000010,
    S_WAIT  = 8'b00000100,
    S_PROBE = 8'b00001000,
    S_RD    = 8'b00010000,
    S_SCAN  = 8'b00100000,
    S_SHASH = 8'b01000000,
    S_SWAIT = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [1:0] lat, lat_next;

  always_comb begin
    state_next = state;
    lat_next = 2'd0;
    cmd = '{op: lphm_pkg::OP_NONE, respond: 1'b0, status: lphm_pkg::ST_MISSING,
            give_value: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = lphm_pkg::OP_LOAD;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.op = lphm_pkg::OP_HASH;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.hash_done) begin
          cmd.op = lphm_pkg::OP_READ;
          state_next = S_RD;
        end
      end
      S_RD: begin
        // Wait here while pos moves and the slot key, value and occupied bit are registered.
        lat_next = lat + 2'd1;
        if (lat == 2'd1) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!stat.occupied) begin
          cmd.respond = 1'b1;
          state_next = S_IDLE;
          if (stat.command == lphm_pkg::CMD_PUT) begin
            if (stat.full) begin
              cmd.status = lphm_pkg::ST_FULL;
            end else begin
              cmd.op = lphm_pkg::OP_WRITE;
              cmd.status = lphm_pkg::ST_INSERTED;
            end
          end
        end else if (stat.key_match) begin
          cmd.respond = 1'b1;
          state_next = S_IDLE;
          case (stat.command)
            lphm_pkg::CMD_PUT: begin
              cmd.op = lphm_pkg::OP_UPDATE;
              cmd.status = lphm_pkg::ST_UPDATED;
            end
            lphm_pkg::CMD_GET: begin
              cmd.status = lphm_pkg::ST_FOUND;
              cmd.give_value = 1'b1;
            end
            lphm_pkg::CMD_TAKE: begin
              cmd.respond = 1'b0;
              cmd.op = lphm_pkg::OP_CLEAR;
              state_next = S_SCAN;
            end
            default: cmd.status = lphm_pkg::ST_MISSING;
          endcase
        end else begin
          cmd.op = lphm_pkg::OP_NEXT;
          state_next = S_RD;
        end
      end
      S_SCAN: begin
        cmd.op = lphm_pkg::OP_NEXT;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        lat_next = lat + 2'd1;
        if (lat == 2'd1) begin
          state_next = S_SHASH;
          lat_next = 2'd0;
        end
      end
      S_SHASH: begin
        if (!stat.occupied) begin
          cmd.respond = 1'b1;
          cmd.status = lphm_pkg::ST_FOUND;
          cmd.give_value = 1'b1;
          state_next = S_IDLE;
        end else if (lat == 2'd0) begin
          cmd.op = lphm_pkg::OP_SHASH;
          lat_next = 2'd1;
        end else if (!stat.hash_done) begin
          lat_next = 2'd1;
        end else begin
          if (!stat.stays) cmd.op = lphm_pkg::OP_MOVE;
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lat <= 2'd0;
    end else begin
      state <= state_next;
      lat <= lat_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_HASH)) else $error("start lost");
  a_respond_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> (state == S_IDLE)) else $error("respond not final");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not onehot");

endmodule

>>> rtl/core/linear_probe_hash_map_unit.sv
// Open-addressing key/value table with 256 slots and linear probing; a
// command is taken when start is high and busy is low, and its one result
// word appears on rsp for a single cycle with done high, which the receiver
// must take. A command hashes its key and probes from its home slot until it
// finds the key or an empty slot; busy drops in the cycle the word appears.
// A take walks the run behind the removed slot up to the empty slot that
// ends it before its word appears, rehashing each key in the one shared hash
// unit, which builds every multiply from 32x32 products. The table is empty
// after reset with no clearing pass. Inserts of new keys are refused with a
// full status once three-quarters load would be reached.
module linear_probe_hash_map_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lphm_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output lphm_pkg::rsp_t rsp
);

  lphm_pkg::cmd_t  cmd;
  lphm_pkg::stat_t stat;

  lphm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  lphm_datapath u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .stat(stat), .rsp(rsp),
    .rsp_valid(done)
  );

endmodule

>>> bench/linear_probe_hash_map_unit_tb.sv
module linear_probe_hash_map_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 740;

  logic clk;
  logic rst;
  logic start;
  lphm_pkg::req_t req;
  logic busy;
  logic done;
  lphm_pkg::rsp_t rsp;

  linear_probe_hash_map_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  typedef struct {
    lphm_pkg::req_t cmd;
    logic has_answer;
    lphm_pkg::rsp_t answer;
  } row_t;

  logic                            shadow_used [lphm_pkg::TABLE_SLOTS];
  logic [lphm_pkg::KEY_BITS-1:0]   shadow_key  [lphm_pkg::TABLE_SLOTS];
  logic [lphm_pkg::VALUE_BITS-1:0] shadow_value[lphm_pkg::TABLE_SLOTS];
  int unsigned                     shadow_total;

  lphm_pkg::rsp_t pending_rsp[$];
  logic [lphm_pkg::KEY_BITS-1:0] known_keys[$];
  int errors;
  int quiet_cycles;
  logic no_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned home_slot(logic [lphm_pkg::KEY_BITS-1:0] k);
    logic [63:0] x;
    x = k;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    x = x * lphm_pkg::MIX_A;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    x = x * lphm_pkg::MIX_B;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    return 32'(x[lphm_pkg::SLOT_BITS-1:0]);
  endfunction

  function automatic logic find_slot(logic [lphm_pkg::KEY_BITS-1:0] k,
                                     output int unsigned pos);
    int unsigned i;
    i = home_slot(k);
    for (int n = 0; n < lphm_pkg::TABLE_SLOTS; n++) begin
      if (!shadow_used[i]) begin
        pos = i;
        return 1'b0;
      end
      if (shadow_key[i] == k) begin
        pos = i;
        return 1'b1;
      end
      i = (i + 1) % lphm_pkg::TABLE_SLOTS;
    end
    pos = i;
    return 1'b0;
  endfunction

  function automatic void close_gap(int unsigned i);
    int unsigned j;
    int unsigned h;
    logic stays;
    j = i;
    shadow_used[i] = 1'b0;
    shadow_total--;
    for (int n = 0; n < lphm_pkg::TABLE_SLOTS; n++) begin
      j = (j + 1) % lphm_pkg::TABLE_SLOTS;
      if (!shadow_used[j]) break;
      h = home_slot(shadow_key[j]);
      stays = (i < j) ? (i < h && h <= j) : (i < h || h <= j);
      if (!stays) begin
        shadow_key[i] = shadow_key[j];
        shadow_value[i] = shadow_value[j];
        shadow_used[i] = 1'b1;
        shadow_used[j] = 1'b0;
        i = j;
      end
    end
  endfunction

  function automatic lphm_pkg::rsp_t table_apply(lphm_pkg::req_t c);
    lphm_pkg::rsp_t r;
    int unsigned pos;
    logic hit;
    r.status = lphm_pkg::ST_MISSING;
    r.found_value = '0;
    hit = find_slot(c.lookup_key, pos);
    case (c.command)
      lphm_pkg::CMD_PUT: begin
        if (hit) begin
          shadow_value[pos] = c.entry_value;
          r.status = lphm_pkg::ST_UPDATED;
        end else if ((shadow_total + 1) * 4 >= lphm_pkg::TABLE_SLOTS * 3) begin
          r.status = lphm_pkg::ST_FULL;
        end else begin
          shadow_key[pos] = c.lookup_key;
          shadow_value[pos] = c.entry_value;
          shadow_used[pos] = 1'b1;
          shadow_total++;
          r.status = lphm_pkg::ST_INSERTED;
        end
      end
      lphm_pkg::CMD_GET: begin
        if (hit) begin
          r.status = lphm_pkg::ST_FOUND;
          r.found_value = shadow_value[pos];
        end
      end
      lphm_pkg::CMD_TAKE: begin
        if (hit) begin
          r.status = lphm_pkg::ST_FOUND;
          r.found_value = shadow_value[pos];
          close_gap(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = lphm_pkg::COUNT_BITS'(shadow_total);
    return r;
  endfunction

  function automatic logic [lphm_pkg::KEY_BITS-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(lphm_pkg::req_t c, logic has_answer, lphm_pkg::rsp_t answer);
    lphm_pkg::rsp_t predicted;
    if (!no_gaps) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    req <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = table_apply(c);
    if (has_answer && predicted !== answer) begin
      $display("%0t table answer disagrees: expected %p actual %p", $time, answer, predicted);
      errors++;
    end
    pending_rsp.push_back(has_answer ? answer : predicted);
    if (c.command == lphm_pkg::CMD_PUT) known_keys.push_back(c.lookup_key);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic lphm_pkg::rsp_t mk(logic [2:0] s, logic [lphm_pkg::VALUE_BITS-1:0] v,
                                        int unsigned n);
    lphm_pkg::rsp_t r;
    r.status = s;
    r.found_value = v;
    r.entry_count = lphm_pkg::COUNT_BITS'(n);
    return r;
  endfunction

  function automatic lphm_pkg::req_t mkreq(logic [1:0] c, logic [lphm_pkg::KEY_BITS-1:0] k,
                                           logic [lphm_pkg::VALUE_BITS-1:0] v);
    lphm_pkg::req_t r;
    r.command = c;
    r.lookup_key = k;
    r.entry_value = v;
    return r;
  endfunction

  always @(posedge clk) begin
    lphm_pkg::rsp_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected word: actual %p", $time, rsp);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status || rsp.found_value !== want.found_value ||
              rsp.entry_count !== want.entry_count) begin
            $display("%0t mismatch: expected %p actual %p", $time, want, rsp);
            errors++;
          end
        end
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  row_t rows[$];

  initial begin
    lphm_pkg::req_t c;
    int r;
    logic [lphm_pkg::KEY_BITS-1:0] k;
    rst = 1'b1;
    start <= 1'b0;
    req <= '0;
    errors = 0;
    no_gaps = 1'b0;
    shadow_total = 0;
    for (int i = 0; i < lphm_pkg::TABLE_SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_GET, '0, '0), 1'b1,
                          mk(lphm_pkg::ST_MISSING, '0, 0)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_TAKE, '1, '1), 1'b1,
                          mk(lphm_pkg::ST_MISSING, '0, 0)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_UNUSED, '1, '1), 1'b1,
                          mk(lphm_pkg::ST_MISSING, '0, 0)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_PUT, '0, '1), 1'b1,
                          mk(lphm_pkg::ST_INSERTED, '0, 1)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_PUT, '1, '0), 1'b1,
                          mk(lphm_pkg::ST_INSERTED, '0, 2)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_GET, '0, '0), 1'b1,
                          mk(lphm_pkg::ST_FOUND, '1, 2)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_PUT, '0, 32'h5a5a_a5a5), 1'b1,
                          mk(lphm_pkg::ST_UPDATED, '0, 2)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_GET, '1, '1), 1'b1,
                          mk(lphm_pkg::ST_FOUND, '0, 2)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_UNUSED, '0, '0), 1'b1,
                          mk(lphm_pkg::ST_MISSING, '0, 2)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_TAKE, '0, '0), 1'b1,
                          mk(lphm_pkg::ST_FOUND, 32'h5a5a_a5a5, 1)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_GET, '0, '0), 1'b1,
                          mk(lphm_pkg::ST_MISSING, '0, 1)});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_TAKE, '1, '0), 1'b1,
                          mk(lphm_pkg::ST_FOUND, '0, 0)});
    for (int i = 1; i <= 8; i++)
      rows.push_back(row_t'{mkreq(lphm_pkg::CMD_PUT, 64'(i * 256), 32'(i)), 1'b0, '0});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_TAKE, 64'(512), '0), 1'b0, '0});
    rows.push_back(row_t'{mkreq(lphm_pkg::CMD_GET, 64'(1024), '0), 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].has_answer, rows[i].answer);
    drain();

    // Fill the table to the load limit, then exercise full and update there.
    while (shadow_total < lphm_pkg::FULL_LIMIT - 1)
      send_word(mkreq(lphm_pkg::CMD_PUT, rand_key(), $urandom()), 1'b0, '0);
    send_word(mkreq(lphm_pkg::CMD_PUT, rand_key(), $urandom()), 1'b1,
              mk(lphm_pkg::ST_FULL, '0, lphm_pkg::FULL_LIMIT - 1));
    send_word(mkreq(lphm_pkg::CMD_PUT, known_keys[$-1], 32'h1234), 1'b0, '0);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n >= 300 && n < 420);
      r = $urandom_range(99);
      if (known_keys.size() != 0 && $urandom_range(99) < 75)
        k = known_keys[$urandom_range(known_keys.size() - 1)];
      else if ($urandom_range(9) == 0)
        k = {56'h0, 8'($urandom())};
      else
        k = rand_key();
      if (r < 40) c = mkreq(lphm_pkg::CMD_PUT, k, $urandom());
      else if (r < 65) c = mkreq(lphm_pkg::CMD_GET, k, $urandom());
      else if (r < 97) c = mkreq(lphm_pkg::CMD_TAKE, k, $urandom());
      else c = mkreq(lphm_pkg::CMD_UNUSED, k, $urandom());
      send_word(c, 1'b0, '0);
      if (n == 500) drain();
    end
    no_gaps = 1'b0;
    drain();
    repeat (400) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/lphm_pkg.sv
rtl/core/lphm_hash.sv
rtl/core/lphm_datapath.sv
rtl/core/lphm_ctrl.sv
rtl/core/linear_probe_hash_map_unit.sv
bench/linear_probe_hash_map_unit_tb.sv
